// ===== src/cmdj_pkg.sv =====
package cmdj_pkg;

  localparam int ANG_W = 33;
  localparam int CS_W = 33;
  localparam int OUT_W = 21;
  localparam int NUM_W = 64;
  localparam int DEN_W = 44;
  localparam int CORDIC_STEPS = 28;
  localparam int CORDIC_LAT = CORDIC_STEPS + 3;
  localparam int DIV_BITS = 21;
  localparam int DIV_LAT = DIV_BITS + 4;
  localparam int TOT_LAT = CORDIC_LAT + 2 + DIV_LAT;

  localparam logic signed [ANG_W-1:0] ANG_PI = 33'sd843314857;
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI = 33'sd1686629713;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 33'sd421657428;
  localparam logic signed [CS_W-1:0] CORDIC_X0 = 33'sd652032874;
  localparam logic [15:0] GAIN_RESET = 16'd4096;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 21'sd1048575;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -21'sd1048576;

  function automatic logic signed [ANG_W-1:0] atan_q28(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0: v = 33'sd210828714;
      5'd1: v = 33'sd124459457;
      5'd2: v = 33'sd65760959;
      5'd3: v = 33'sd33381290;
      5'd4: v = 33'sd16755422;
      5'd5: v = 33'sd8385879;
      5'd6: v = 33'sd4193963;
      5'd7: v = 33'sd2097109;
      5'd8: v = 33'sd1048571;
      5'd9: v = 33'sd524287;
      default: v = ANG_W'(33'sd1 <<< (5'd28 - idx));
    endcase
    return v;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat21(input logic signed [63:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > 64'(OUT_MAX)) r = OUT_MAX;
    else if (v < 64'(OUT_MIN)) r = OUT_MIN;
    else r = v[OUT_W-1:0];
    return r;
  endfunction

  typedef struct packed {
    logic signed [15:0] speed;
    logic signed [15:0] accel;
    logic signed [15:0] steer_rate;
  } motion_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x_rate;
    logic signed [OUT_W-1:0] y_rate;
    logic signed [OUT_W-1:0] speed_rate;
    logic signed [OUT_W-1:0] steer_angle_rate;
    logic signed [OUT_W-1:0] jac_x_heading;
    logic signed [OUT_W-1:0] jac_x_speed;
    logic signed [OUT_W-1:0] jac_y_speed;
  } direct_t;

endpackage

// ===== src/car_model_derivative_jacobian_core.sv =====
// Evaluates the car model derivative and Jacobian entries for one state and
// control per request. A new request is taken every clock cycle while the
// pipeline is not stalled. Each request passes the two CORDIC pipelines
// (range reduction, 28 rotation steps, sign fix), a product register and a
// rounding register, and the three pipelined restoring dividers that form
// the steering terms. When m_tvalid is high and m_tready is low the whole
// pipeline holds. steer_gain should be written only while no request is in
// flight.
module car_model_derivative_jacobian_core import cmdj_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // heading, speed, steer_angle, accel, steer_rate
  input  logic [79:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // x_rate, y_rate, heading_rate, speed_rate, steer_angle_rate, jac_x_heading,
  // jac_x_speed, jac_y_heading, jac_y_speed, jac_heading_speed,
  // jac_heading_steer, one zero pad bit
  output logic [231:0] m_tdata
);

  logic        en;
  logic [15:0] steer_gain;
  logic [TOT_LAT-1:0] vld;

  logic signed [ANG_W-1:0] head_ang, steer_ang;
  logic signed [CS_W-1:0]  ch, sh, cs, ss;
  motion_t mot [CORDIC_LAT];

  logic signed [48:0] p_xc, p_xs;
  logic signed [65:0] csq;
  logic signed [32:0] spg;
  logic signed [49:0] gss;
  logic signed [CS_W-1:0] ch1, sh1, cs1, ss1;
  logic signed [15:0] ac1, sr1;

  logic signed [NUM_W-1:0] num2, num9, num10;
  logic signed [DEN_W-1:0] den2, den9, den10;
  // The direct terms wait beside the dividers in a delay line that runs from
  // the divider operand registers to the quotients.
  direct_t dir [DIV_LAT+1];
  logic signed [OUT_W-1:0] heading_rate, jac_heading_speed, jac_heading_steer;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[TOT_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_gain <= GAIN_RESET;
      vld <= '0;
    end else begin
      if (cfg_we) steer_gain <= cfg_wdata;
      if (en) vld <= {vld[TOT_LAT-2:0], s_tvalid};
    end
  end

  assign head_ang  = ANG_W'($signed(s_tdata[15:0])) <<< 16;
  assign steer_ang = ANG_W'($signed(s_tdata[47:32])) <<< 14;

  cmdj_cordic u_head (.clk, .en, .angle(head_ang), .cos_o(ch), .sin_o(sh));
  cmdj_cordic u_steer (.clk, .en, .angle(steer_ang), .cos_o(cs), .sin_o(ss));

  always_ff @(posedge clk) begin
    if (en) begin
      mot[0] <= '{speed: s_tdata[31:16], accel: s_tdata[63:48],
                  steer_rate: s_tdata[79:64]};
      for (int i = 1; i < CORDIC_LAT; i++) mot[i] <= mot[i-1];

      // Products, one multiplier deep.
      p_xc <= 49'(mot[CORDIC_LAT-1].speed) * 49'(ch);
      p_xs <= 49'(mot[CORDIC_LAT-1].speed) * 49'(sh);
      csq  <= 66'(cs) * 66'(cs);
      spg  <= 33'(mot[CORDIC_LAT-1].speed) * 33'($signed({1'b0, steer_gain}));
      gss  <= 50'(ss) * 50'($signed({1'b0, steer_gain}));
      ch1  <= ch;
      sh1  <= sh;
      cs1  <= cs;
      ss1  <= ss;
      ac1  <= mot[CORDIC_LAT-1].accel;
      sr1  <= mot[CORDIC_LAT-1].steer_rate;

      // Rounding and the divider operands.
      dir[0].x_rate <= sat21((64'(p_xc) + 64'sd134217728) >>> 28);
      dir[0].y_rate <= sat21((64'(p_xs) + 64'sd134217728) >>> 28);
      dir[0].jac_x_heading <= sat21((-64'(p_xs) + 64'sd134217728) >>> 28);
      dir[0].jac_x_speed <= sat21((64'(ch1) + 64'sd8192) >>> 14);
      dir[0].jac_y_speed <= sat21((64'(sh1) + 64'sd8192) >>> 14);
      dir[0].speed_rate <= OUT_W'(ac1) <<< 2;
      dir[0].steer_angle_rate <= OUT_W'(sr1) <<< 2;
      for (int i = 1; i <= DIV_LAT; i++) dir[i] <= dir[i-1];

      num2  <= 64'(spg) * 64'(ss1);
      den2  <= DEN_W'(cs1) <<< 10;
      num9  <= 64'(gss) <<< 4;
      den9  <= DEN_W'(cs1);
      num10 <= 64'(spg) <<< 20;
      den10 <= DEN_W'((csq + 66'sd536870912) >>> 30);
    end
  end

  cmdj_divider u_div_hr (.clk, .en, .num(num2), .den(den2), .quo(heading_rate));
  cmdj_divider u_div_hs (.clk, .en, .num(num9), .den(den9), .quo(jac_heading_speed));
  cmdj_divider u_div_st (.clk, .en, .num(num10), .den(den10), .quo(jac_heading_steer));

  assign m_tdata = {1'b0, jac_heading_steer, jac_heading_speed,
                    dir[DIV_LAT].jac_y_speed, dir[DIV_LAT].x_rate,
                    dir[DIV_LAT].jac_x_speed, dir[DIV_LAT].jac_x_heading,
                    dir[DIV_LAT].steer_angle_rate, dir[DIV_LAT].speed_rate,
                    heading_rate, dir[DIV_LAT].y_rate, dir[DIV_LAT].x_rate};

endmodule

// ===== src/cmdj_cordic.sv =====
module cmdj_cordic import cmdj_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ANG_W-1:0] angle,
  output logic signed [CS_W-1:0]  cos_o,
  output logic signed [CS_W-1:0]  sin_o
);

  logic signed [ANG_W-1:0] red;
  logic signed [ANG_W-1:0] az [CORDIC_STEPS+1];
  logic signed [CS_W-1:0]  xs [CORDIC_STEPS+1];
  logic signed [CS_W-1:0]  ys [CORDIC_STEPS+1];
  logic                    neg [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      // One wrap brings an input within [-3*pi, 3*pi] into [-pi, pi].
      if (angle > ANG_PI) red <= angle - ANG_TWO_PI;
      else if (angle < -ANG_PI) red <= angle + ANG_TWO_PI;
      else red <= angle;

      xs[0] <= CORDIC_X0;
      ys[0] <= '0;
      if (red > ANG_HALF_PI) begin
        az[0] <= red - ANG_PI;
        neg[0] <= 1'b1;
      end else if (red < -ANG_HALF_PI) begin
        az[0] <= red + ANG_PI;
        neg[0] <= 1'b1;
      end else begin
        az[0] <= red;
        neg[0] <= 1'b0;
      end

      for (int i = 0; i < CORDIC_STEPS; i++) begin
        neg[i+1] <= neg[i];
        if (!az[i][ANG_W-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          az[i+1] <= az[i] - atan_q28(5'(i));
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          az[i+1] <= az[i] + atan_q28(5'(i));
        end
      end

      cos_o <= neg[CORDIC_STEPS] ? -xs[CORDIC_STEPS] : xs[CORDIC_STEPS];
      sin_o <= neg[CORDIC_STEPS] ? -ys[CORDIC_STEPS] : ys[CORDIC_STEPS];
    end
  end

endmodule

// ===== src/cmdj_divider.sv =====
module cmdj_divider import cmdj_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic signed [OUT_W-1:0] quo
);

  logic [63:0] nmag, dmag;
  logic        neg_a, nz_a;

  logic [63:0]         rem [DIV_BITS+2];
  logic [63:0]         dv  [DIV_BITS+2];
  logic [DIV_BITS-1:0] q   [DIV_BITS+2];
  logic                ovf [DIV_BITS+2];
  logic                neg [DIV_BITS+2];
  logic                nz  [DIV_BITS+2];
  logic                ge  [DIV_BITS+1];

  always_comb begin
    for (int s = 0; s <= DIV_BITS; s++) begin
      ge[s] = (rem[s] >> (DIV_BITS - s)) >= dv[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nmag  <= num[NUM_W-1] ? 64'(-num) : 64'(num);
      dmag  <= den[DEN_W-1] ? 64'(-64'(den)) : 64'(den);
      neg_a <= num[NUM_W-1] ^ den[DEN_W-1];
      nz_a  <= (num == '0);

      // Rounding to nearest: add half the divisor before truncating.
      rem[0] <= nmag + (dmag >> 1);
      dv[0]  <= dmag;
      q[0]   <= '0;
      ovf[0] <= 1'b0;
      neg[0] <= neg_a;
      nz[0]  <= nz_a;

      for (int s = 0; s <= DIV_BITS; s++) begin
        dv[s+1]  <= dv[s];
        neg[s+1] <= neg[s];
        nz[s+1]  <= nz[s];
        if (s == 0) begin
          // The top stage only detects a quotient too large for the output.
          rem[s+1] <= rem[s];
          q[s+1]   <= q[s];
          ovf[s+1] <= ge[s];
        end else begin
          ovf[s+1] <= ovf[s];
          q[s+1]   <= {q[s][DIV_BITS-2:0], ge[s]};
          rem[s+1] <= ge[s] ? rem[s] - (dv[s] << (DIV_BITS - s)) : rem[s];
        end
      end

      if (nz[DIV_BITS+1]) quo <= '0;
      else if (ovf[DIV_BITS+1]) quo <= neg[DIV_BITS+1] ? OUT_MIN : OUT_MAX;
      else if (neg[DIV_BITS+1]) begin
        if (q[DIV_BITS+1] > DIV_BITS'(21'd1048576)) quo <= OUT_MIN;
        else quo <= OUT_W'(-{1'b0, q[DIV_BITS+1]});
      end else begin
        if (q[DIV_BITS+1][DIV_BITS-1]) quo <= OUT_MAX;
        else quo <= OUT_W'(q[DIV_BITS+1]);
      end
    end
  end

endmodule

// ===== src/cmdj_checker.sv =====
module cmdj_port_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [231:0] m_tdata
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output stage is empty");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[231])
    else $error("pad bit set");

  // The y/heading Jacobian entry equals the x rate by construction.
  a_dup: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[167:147] == m_tdata[20:0])
    else $error("jac_y_heading differs from x_rate");

endmodule

bind car_model_derivative_jacobian_core cmdj_port_checker u_cmdj_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata)
);
